>>> rtl/pcl_pkg.sv
// shared types and constants of the polygon plane clipper
`default_nettype none
package pcl_pkg;
  localparam int CW    = 32;             // coordinate width
  localparam int FB    = 16;             // fraction bits
  localparam int TB    = 32;             // fraction bits of the edge parameter t
  localparam int NATTR = 9;              // attributes per vertex
  localparam int DW    = 2*CW - FB + 2;  // plane distance width
  localparam int NW    = DW + 1;         // divider operand width
  localparam int RW    = NW + 1;         // divider remainder width
  localparam int LPW   = CW + TB + 3;    // lerp product width
  localparam int AIW   = $clog2(NATTR);  // attribute index width
  localparam int CNTW  = $clog2(TB);     // sequencer counter width

  // pending result slots of one transaction, in output order
  localparam int PH_X1 = 0;  // crossing of previous->current edge
  localparam int PH_V1 = 1;  // current vertex
  localparam int PH_X2 = 2;  // crossing of closing edge
  localparam int PH_V2 = 3;  // first vertex
  localparam int PH_M  = 4;  // end marker
  localparam int NPH   = 5;

  localparam logic EDGE_PREV  = 1'b0;
  localparam logic EDGE_CLOSE = 1'b1;

  typedef logic [NATTR-1:0][CW-1:0] vec_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIST, ST_PLAN, ST_PICK, ST_DIV, ST_LERP, ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    SRC_CROSS, SRC_CUR, SRC_FIRST, SRC_MARK
  } src_t;

  typedef struct packed {
    logic           capture;
    logic           mul_en;
    logic [1:0]     mul_idx;
    logic           acc_add;
    logic           set_first;
    logic           commit;
    logic           div_init;
    logic           div_step;
    logic           lmul_en;
    logic [AIW-1:0] lmul_idx;
    logic           ladd_en;
    logic [AIW-1:0] ladd_idx;
    logic           edge_sel;
    logic           load_out;
    src_t           src;
    logic           out_last;
  } cmd_t;

  typedef struct packed {
    logic cur_in;
    logic prev_in;
    logic first_in;
    logic out_free;
  } sts_t;
endpackage
`default_nettype wire

>>> rtl/polygon_plane_clip_top.sv
// top level of the polygon plane clipper
//
// Clips a polygon streamed one vertex per input transaction against the plane
// a*x+b*y+c*z+d > 0. Input and output channels use valid/ready; last_vertex
// closes the polygon and an end marker (item_kind=1, zero fields) follows its
// results. last_of_run flags the final result caused by one input.
// Plane registers are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while idle, as the block itself does not enforce it.
// Per input vertex the sequencer runs capture, the distance (three products from
// one multiplier), plan, then each result and at last commit before the next
// in_ready; a plain result is loaded directly, an intersection needs setup, a
// restoring divider for t, lerp through a single multiplier over the nine
// attributes and emit.
// The block takes one vertex at a time; in_ready is high only between vertices.
// A one-entry output register holds a finished result; when the receiver
// stalls the sequencer waits with the next result until the slot frees.
// Synchronous reset returns the plane to x+1>0 and forgets any open polygon.
`default_nettype none
module polygon_plane_clip_top (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [pcl_pkg::CW-1:0] cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [pcl_pkg::CW-1:0] pos_x,
  input  wire logic [pcl_pkg::CW-1:0] pos_y,
  input  wire logic [pcl_pkg::CW-1:0] pos_z,
  input  wire logic [pcl_pkg::CW-1:0] col_r,
  input  wire logic [pcl_pkg::CW-1:0] col_g,
  input  wire logic [pcl_pkg::CW-1:0] col_b,
  input  wire logic [pcl_pkg::CW-1:0] norm_x,
  input  wire logic [pcl_pkg::CW-1:0] norm_y,
  input  wire logic [pcl_pkg::CW-1:0] norm_z,
  input  wire logic                   last_vertex,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [pcl_pkg::CW-1:0]      out_x,
  output logic [pcl_pkg::CW-1:0]      out_y,
  output logic [pcl_pkg::CW-1:0]      out_z,
  output logic [pcl_pkg::CW-1:0]      out_r,
  output logic [pcl_pkg::CW-1:0]      out_g,
  output logic [pcl_pkg::CW-1:0]      out_b,
  output logic [pcl_pkg::CW-1:0]      out_nx,
  output logic [pcl_pkg::CW-1:0]      out_ny,
  output logic [pcl_pkg::CW-1:0]      out_nz,
  output logic                        item_kind,
  output logic                        last_of_run
);
  import pcl_pkg::*;

  cmd_t cmd;
  sts_t sts;
  vec_t in_attr, out_attr;

  assign in_attr = {norm_z, norm_y, norm_x, col_b, col_g, col_r, pos_z, pos_y, pos_x};

  pcl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_last  (last_vertex),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pcl_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_attr   (in_attr),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_attr  (out_attr),
    .out_kind  (item_kind),
    .out_last  (last_of_run)
  );

  assign out_x  = out_attr[0];
  assign out_y  = out_attr[1];
  assign out_z  = out_attr[2];
  assign out_r  = out_attr[3];
  assign out_g  = out_attr[4];
  assign out_b  = out_attr[5];
  assign out_nx = out_attr[6];
  assign out_ny = out_attr[7];
  assign out_nz = out_attr[8];
endmodule
`default_nettype wire

>>> rtl/pcl_ctrl.sv
// sequencer of the polygon plane clipper
`default_nettype none
module pcl_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          in_last,
  output logic               in_ready,
  input  wire pcl_pkg::sts_t sts,
  output pcl_pkg::cmd_t      cmd
);
  import pcl_pkg::*;

  state_t          state, state_next;
  logic [CNTW-1:0] cnt, cnt_next;
  logic [NPH-1:0]  mask, mask_next;
  logic            last_r, last_r_next;
  logic            mid, mid_next;
  logic            edge_r, edge_r_next;
  logic [NPH-1:0]  low_bit, rest;
  logic            fi;

  assign low_bit = mask & (~mask + NPH'(1));
  assign rest    = mask & ~low_bit;
  assign fi      = mid ? sts.first_in : sts.cur_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cnt    <= '0;
      mask   <= '0;
      last_r <= 1'b0;
      mid    <= 1'b0;
      edge_r <= EDGE_PREV;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      mask   <= mask_next;
      last_r <= last_r_next;
      mid    <= mid_next;
      edge_r <= edge_r_next;
    end
  end

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    mask_next   = mask;
    last_r_next = last_r;
    mid_next    = mid;
    edge_r_next = edge_r;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.edge_sel = edge_r;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          last_r_next = in_last;
          cnt_next    = '0;
          state_next  = ST_DIST;
        end
      end
      ST_DIST: begin
        // products issue on counts 0..2 and accumulate on counts 1..3
        cmd.mul_en  = (cnt < CNTW'(3));
        cmd.mul_idx = cnt[1:0];
        cmd.acc_add = (cnt != '0);
        if (cnt == CNTW'(3)) begin
          state_next = ST_PLAN;
        end else begin
          cnt_next = cnt + CNTW'(1);
        end
      end
      ST_PLAN: begin
        mask_next        = '0;
        mask_next[PH_X1] = mid && (sts.prev_in != sts.cur_in);
        mask_next[PH_V1] = mid && sts.cur_in;
        mask_next[PH_X2] = last_r && (sts.cur_in != fi);
        mask_next[PH_V2] = last_r && fi;
        mask_next[PH_M]  = last_r;
        cmd.set_first    = !mid;
        state_next       = ST_PICK;
      end
      ST_PICK: begin
        if (mask == '0) begin
          cmd.commit = 1'b1;
          mid_next   = !last_r;
          state_next = ST_IDLE;
        end else if (low_bit[PH_X1] || low_bit[PH_X2]) begin
          edge_r_next  = low_bit[PH_X2] ? EDGE_CLOSE : EDGE_PREV;
          cmd.edge_sel = edge_r_next;
          cmd.div_init = 1'b1;
          cnt_next     = '0;
          state_next   = ST_DIV;
        end else if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_last = (rest == '0);
          cmd.src      = low_bit[PH_V1] ? SRC_CUR :
                         (low_bit[PH_V2] ? SRC_FIRST : SRC_MARK);
          mask_next    = rest;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == CNTW'(TB-1)) begin
          cnt_next   = '0;
          state_next = ST_LERP;
        end else begin
          cnt_next = cnt + CNTW'(1);
        end
      end
      ST_LERP: begin
        cmd.lmul_en  = (cnt < CNTW'(NATTR));
        cmd.lmul_idx = cnt[AIW-1:0];
        cmd.ladd_en  = (cnt != '0);
        cmd.ladd_idx = cnt[AIW-1:0] - AIW'(1);
        if (cnt == CNTW'(NATTR)) begin
          state_next = ST_EMIT;
        end else begin
          cnt_next = cnt + CNTW'(1);
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.src      = SRC_CROSS;
          cmd.out_last = (rest == '0);
          mask_next    = rest;
          state_next   = ST_PICK;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/pcl_dp.sv
// datapath: plane registers, vertex store, distance, divider, lerp, output register
`default_nettype none
module pcl_dp (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [pcl_pkg::CW-1:0] cfg_data,
  input  wire pcl_pkg::vec_t      in_attr,
  input  wire logic               out_ready,
  input  wire pcl_pkg::cmd_t      cmd,
  output pcl_pkg::sts_t           sts,
  output logic                    out_valid,
  output pcl_pkg::vec_t           out_attr,
  output logic                    out_kind,
  output logic                    out_last
);
  import pcl_pkg::*;

  logic signed [CW-1:0]   plane_a, plane_b, plane_c, plane_d;
  vec_t                   cur, prev, first, stage;
  logic signed [DW-1:0]   acc, prev_dist, first_dist;
  logic                   prev_in, first_in;
  logic signed [2*CW-1:0] prod;
  logic signed [CW-1:0]   mcoef, mcoord;
  logic [NW-1:0]          den;
  logic [RW-1:0]          rem, rem2;
  logic [TB-1:0]          tq;
  logic                   full;
  logic [TB:0]            t_eff;
  logic signed [LPW-1:0]  lprod;
  logic signed [DW-1:0]   dp, dc;
  logic signed [NW-1:0]   dp_x, ddiff;
  logic [NW-1:0]          num_abs, den_abs;
  vec_t                   pv, cv;
  logic signed [CW:0]     adiff;
  logic                   cur_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_a <= CW'(1) << FB;
      plane_b <= '0;
      plane_c <= '0;
      plane_d <= CW'(1) << FB;
    end else if (cfg_we) begin
      unique case (cfg_index)
        2'd0: plane_a <= cfg_data;
        2'd1: plane_b <= cfg_data;
        2'd2: plane_c <= cfg_data;
        2'd3: plane_d <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cmd.mul_idx)
      2'd0:    begin mcoef = plane_a; mcoord = cur[0]; end
      2'd1:    begin mcoef = plane_b; mcoord = cur[1]; end
      default: begin mcoef = plane_c; mcoord = cur[2]; end
    endcase
  end

  assign cur_in = (acc > 0);

  // edge endpoints: previous->current or current->first
  assign dp      = (cmd.edge_sel == EDGE_CLOSE) ? acc : prev_dist;
  assign dc      = (cmd.edge_sel == EDGE_CLOSE) ? first_dist : acc;
  assign dp_x    = {dp[DW-1], dp};
  assign ddiff   = dp_x - {dc[DW-1], dc};
  assign num_abs = dp_x[NW-1] ? NW'(-dp_x) : NW'(dp_x);
  assign den_abs = ddiff[NW-1] ? NW'(-ddiff) : NW'(ddiff);
  assign pv      = (cmd.edge_sel == EDGE_CLOSE) ? cur : prev;
  assign cv      = (cmd.edge_sel == EDGE_CLOSE) ? first : cur;
  assign rem2    = {rem[RW-2:0], 1'b0};
  assign t_eff   = full ? {1'b1, {TB{1'b0}}} : {1'b0, tq};
  assign adiff   = $signed({cv[cmd.lmul_idx][CW-1], cv[cmd.lmul_idx]})
                 - $signed({pv[cmd.lmul_idx][CW-1], pv[cmd.lmul_idx]});

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur <= in_attr;
      acc <= {{(DW-CW){plane_d[CW-1]}}, plane_d};
    end else if (cmd.acc_add) begin
      acc <= acc + DW'(prod >>> FB);
    end
    if (cmd.mul_en) prod <= mcoef * mcoord;
    if (cmd.set_first) begin
      first      <= cur;
      first_dist <= acc;
      first_in   <= cur_in;
    end
    if (cmd.commit) begin
      prev      <= cur;
      prev_dist <= acc;
      prev_in   <= cur_in;
    end
    if (cmd.div_init) begin
      rem  <= {1'b0, num_abs};
      den  <= den_abs;
      tq   <= '0;
      full <= (num_abs >= den_abs);
    end else if (cmd.div_step && !full) begin
      if (rem2 >= {1'b0, den}) begin
        rem <= rem2 - {1'b0, den};
        tq  <= {tq[TB-2:0], 1'b1};
      end else begin
        rem <= rem2;
        tq  <= {tq[TB-2:0], 1'b0};
      end
    end
    if (cmd.lmul_en) lprod <= adiff * $signed({1'b0, t_eff});
    if (cmd.ladd_en) stage[cmd.ladd_idx] <= pv[cmd.ladd_idx] + CW'(lprod >>> TB);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      unique case (cmd.src)
        SRC_CROSS: out_attr <= stage;
        SRC_CUR:   out_attr <= cur;
        SRC_FIRST: out_attr <= first;
        default:   out_attr <= '0;
      endcase
      out_kind <= (cmd.src == SRC_MARK);
      out_last <= cmd.out_last;
    end
  end

  assign sts.cur_in   = cur_in;
  assign sts.prev_in  = prev_in;
  assign sts.first_in = first_in;
  assign sts.out_free = !out_valid || out_ready;
endmodule
`default_nettype wire

>>> rtl/pcl_checker.sv
// port-level checks of the polygon plane clipper, bound to the top level
`default_nettype none
module pcl_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [31:0] out_x,
  input wire logic item_kind,
  input wire logic last_of_run
);
  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // end marker carries a zero out_x and closes the run
  a_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_kind |-> out_x == 32'd0 && last_of_run)
    else $error("malformed end marker");

  // one vertex at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

  // nothing is offered right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered after reset");
endmodule

bind polygon_plane_clip_top pcl_checker u_pcl_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_x       (out_x),
  .item_kind   (item_kind),
  .last_of_run (last_of_run)
);
`default_nettype wire

>>> tb/clip_checker.sv
// watches the clipper channels, predicts clipped vertices and compares results
module clip_checker (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [pcl_pkg::CW-1:0] cfg_data,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  pcl_pkg::vec_t          in_vtx,
  input  logic                   last_vertex,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  pcl_pkg::vec_t          out_vtx,
  input  logic                   item_kind,
  input  logic                   last_of_run,
  output int                     failures,
  output int                     pending,
  output int                     checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import pcl_pkg::*;

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_MARKER = 1'b1;
  localparam logic [1:0] REG_A = 2'd0;
  localparam logic [1:0] REG_B = 2'd1;
  localparam logic [1:0] REG_C = 2'd2;
  localparam logic [1:0] REG_D = 2'd3;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    vec_t v;
    logic kind;
    logic fin;
  } clip_res_t;

  const string attr_name[NATTR] = '{"out_x", "out_y", "out_z", "out_r", "out_g", "out_b",
                                    "out_nx", "out_ny", "out_nz"};

  logic signed [CW-1:0] pl_a, pl_b, pl_c, pl_d;
  vec_t                 first_v, prev_v;
  wide_t                first_dist, prev_dist;
  logic                 first_in, prev_in, poly_open;
  clip_res_t            clipped_q[$];

  function automatic void enqueue(clip_res_t r);
    clipped_q = {clipped_q, r};
  endfunction

  function automatic wide_t plane_dist(vec_t v);
    wide_t s, ca, cb, cc, x, y, z;
    s = wide_t'(pl_d);
    ca = wide_t'(pl_a);
    cb = wide_t'(pl_b);
    cc = wide_t'(pl_c);
    x = wide_t'(signed'(v[0]));
    y = wide_t'(signed'(v[1]));
    z = wide_t'(signed'(v[2]));
    s = s + ((ca * x) >>> FB) + ((cb * y) >>> FB) + ((cc * z) >>> FB);
    return s;
  endfunction

  // t = |dp| / |dp-dc| in Q1.32, then lerp of every attribute
  function automatic vec_t crossing(vec_t p, wide_t dp, vec_t c, wide_t dc);
    wide_t num, den, t, pv, cv, prod;
    vec_t  r;
    num = (dp < 0) ? -dp : dp;
    den = dp - dc;
    if (den < 0) den = -den;
    if (num >= den) t = wide_t'(1) <<< TB;
    else t = (num <<< TB) / den;
    for (int i = 0; i < NATTR; i++) begin
      pv = wide_t'(signed'(p[i]));
      cv = wide_t'(signed'(c[i]));
      prod = ((cv - pv) * t) >>> TB;
      r[i] = CW'(pv + prod);
    end
    return r;
  endfunction

  function automatic void push_edge(vec_t p, wide_t dp, logic inp, vec_t c, wide_t dc,
                                    logic inc);
    if (inp != inc) enqueue('{crossing(p, dp, c, dc), KIND_VERTEX, 1'b0});
    if (inc) enqueue('{c, KIND_VERTEX, 1'b0});
  endfunction

  function automatic void predict(vec_t cur, logic lst);
    wide_t dc;
    logic  inc;
    int    base;
    base = clipped_q.size();
    dc = plane_dist(cur);
    inc = dc > 0;
    if (!poly_open) begin
      first_v = cur;
      first_dist = dc;
      first_in = inc;
    end else begin
      push_edge(prev_v, prev_dist, prev_in, cur, dc, inc);
    end
    if (lst) begin
      push_edge(cur, dc, inc, first_v, first_dist, first_in);
      enqueue('{'0, KIND_MARKER, 1'b0});
      poly_open = 1'b0;
    end else begin
      poly_open = 1'b1;
    end
    prev_v = cur;
    prev_dist = dc;
    prev_in = inc;
    if (clipped_q.size() > base) clipped_q[$].fin = 1'b1;
  endfunction

  always @(posedge clk) begin
    clip_res_t exp_r;
    int        errs;
    errs = 0;
    if (rst) begin
      pl_a <= CW'(1) << FB;
      pl_b <= '0;
      pl_c <= '0;
      pl_d <= CW'(1) << FB;
      poly_open = 1'b0;
      first_v = '0;
      prev_v = '0;
      first_dist = '0;
      prev_dist = '0;
      first_in = 1'b0;
      prev_in = 1'b0;
      clipped_q.delete();
      failures <= 0;
      checked <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_A: pl_a <= cfg_data;
          REG_B: pl_b <= cfg_data;
          REG_C: pl_c <= cfg_data;
          REG_D: pl_d <= cfg_data;
        endcase
      end
      if (in_valid && in_ready) predict(in_vtx, last_vertex);
      if (out_valid && out_ready) begin
        checked <= checked + 1;
        if (clipped_q.size() == 0) begin
          $error("result transaction with nothing expected");
          errs++;
        end else begin
          exp_r = clipped_q.pop_front();
          for (int i = 0; i < NATTR; i++)
            if (out_vtx[i] !== exp_r.v[i]) begin
              $error("%s: expected %h, got %h", attr_name[i], exp_r.v[i], out_vtx[i]);
              errs++;
            end
          if (item_kind !== exp_r.kind) begin
            $error("item_kind: expected %b, got %b", exp_r.kind, item_kind);
            errs++;
          end
          if (last_of_run !== exp_r.fin) begin
            $error("last_of_run: expected %b, got %b", exp_r.fin, last_of_run);
            errs++;
          end
        end
      end
      failures <= failures + errs;
    end
    pending <= clipped_q.size();
  end
endmodule

>>> tb/tb_top.sv
// stimulus and verdict for the polygon plane clipper
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pcl_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN = 150;
  localparam logic [1:0] REG_A = 2'd0;
  localparam logic [1:0] REG_B = 2'd1;
  localparam logic [1:0] REG_C = 2'd2;
  localparam logic [1:0] REG_D = 2'd3;
  localparam logic [CW-1:0] ONE = CW'(1) << FB;
  localparam logic [CW-1:0] MAX_POS = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] MAX_NEG = {1'b1, {(CW-1){1'b0}}};

  logic clk = 1'b0, rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [CW-1:0] cfg_data = '0;
  logic in_valid = 1'b0, in_ready, last_vertex = 1'b0;
  vec_t in_vtx = '0, out_vtx;
  logic out_valid, out_ready = 1'b0, item_kind, last_of_run;
  int failures, pending, checked;
  int send_idle = 0, recv_idle = 0;
  int cycles = 0, vertices = 0, polygons = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  polygon_plane_clip_top i_dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .in_valid, .in_ready,
    .pos_x(in_vtx[0]), .pos_y(in_vtx[1]), .pos_z(in_vtx[2]),
    .col_r(in_vtx[3]), .col_g(in_vtx[4]), .col_b(in_vtx[5]),
    .norm_x(in_vtx[6]), .norm_y(in_vtx[7]), .norm_z(in_vtx[8]),
    .last_vertex, .out_valid, .out_ready,
    .out_x(out_vtx[0]), .out_y(out_vtx[1]), .out_z(out_vtx[2]),
    .out_r(out_vtx[3]), .out_g(out_vtx[4]), .out_b(out_vtx[5]),
    .out_nx(out_vtx[6]), .out_ny(out_vtx[7]), .out_nz(out_vtx[8]),
    .item_kind, .last_of_run
  );

  clip_checker i_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

  function automatic logic [CW-1:0] rand_val();
    logic [CW-1:0] r;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: r = CW'($urandom_range(524288)) - CW'(262144);
      5, 6, 7:       r = $urandom;
      8:             r = (CW'($urandom_range(8)) - CW'(4)) << FB;
      default: begin
        case ($urandom_range(4))
          0: r = MAX_POS;
          1: r = MAX_NEG;
          2: r = '0;
          3: r = '1;
          default: r = CW'(1);
        endcase
      end
    endcase
    return r;
  endfunction

  function automatic vec_t rand_vertex();
    vec_t v;
    for (int i = 0; i < NATTR; i++) v[i] = rand_val();
    return v;
  endfunction

  task automatic send_vertex(vec_t v, logic lst);
    if ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_vtx = v;
    last_vertex = lst;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    vertices++;
    if (lst) polygons++;
    @(negedge clk);
  endtask

  // wait out all results plus the work of any vertex that produces none
  task automatic settle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CW-1:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_polygon(int n);
    for (int i = 0; i < n; i++) send_vertex(rand_vertex(), i == n - 1);
  endtask

  function automatic vec_t at_x(logic [CW-1:0] x);
    vec_t v;
    v = rand_vertex();
    v[0] = x;
    return v;
  endfunction

  initial begin
    vec_t v;
    int n;
    repeat (8) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // reset plane x+1>0: single-vertex polygons inside and outside
    send_vertex(at_x('0), 1'b1);
    send_vertex(at_x(-(ONE << 1)), 1'b1);
    // vertex exactly on the plane counts as outside
    send_vertex(at_x(-ONE), 1'b0);
    send_vertex(at_x(ONE), 1'b0);
    send_vertex(at_x(-(ONE * 3)), 1'b1);
    // lerp between attribute extremes
    v = at_x(MAX_NEG);
    for (int i = 1; i < NATTR; i++) v[i] = MAX_NEG;
    send_vertex(v, 1'b0);
    v = at_x(MAX_POS);
    for (int i = 1; i < NATTR; i++) v[i] = MAX_POS;
    send_vertex(v, 1'b0);
    send_vertex(at_x(MAX_NEG), 1'b1);
    // all-inside and all-outside quads
    for (int i = 0; i < 4; i++) send_vertex(at_x(ONE << i), i == 3);
    for (int i = 0; i < 4; i++) send_vertex(at_x(-(ONE << (i + 1))), i == 3);
    // plane rewritten while a polygon is open
    send_vertex(at_x(ONE), 1'b0);
    send_vertex(at_x(-(ONE << 2)), 1'b0);
    settle();
    write_reg(REG_D, ONE * 8);
    send_vertex(at_x(-(ONE << 1)), 1'b0);
    send_vertex(at_x(-(ONE * 12)), 1'b1);
    settle();
    // extreme plane
    write_reg(REG_A, MAX_POS);
    write_reg(REG_B, MAX_NEG);
    write_reg(REG_C, CW'(1));
    write_reg(REG_D, MAX_NEG);
    send_polygon(4);
    send_polygon(3);
    settle();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 11 : (ph == 1) ? 54 : 0;
      recv_idle = (ph == 0) ? 54 : (ph == 1) ? 11 : 0;
      for (int g = 0; g < 3; g++) begin
        if (g == 2 && ph == 1) begin
          write_reg(REG_A, MAX_NEG);
          write_reg(REG_B, MAX_POS);
          write_reg(REG_C, MAX_NEG);
          write_reg(REG_D, MAX_POS);
        end else begin
          write_reg(REG_A, rand_val());
          write_reg(REG_B, rand_val());
          write_reg(REG_C, rand_val());
          write_reg(REG_D, rand_val());
        end
        n = vertices;
        while (vertices - n < 21) begin
          // mostly triangles to pentagons, now and then degenerate or larger
          case ($urandom_range(9))
            0:       send_polygon(1);
            1:       send_polygon($urandom_range(6, 8));
            2:       send_polygon(2);
            default: send_polygon(0 + $urandom_range(3, 5));
          endcase
        end
        settle();
      end
    end

    $display("tb: %0d vertices in %0d polygons sent, %0d clipped results checked",
             vertices, polygons, checked);
    $display("tb: planes covered reset, extreme and random coefficients under all idle mixes");
    if (failures == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

>>> filelist.f
rtl/pcl_pkg.sv
rtl/pcl_ctrl.sv
rtl/pcl_dp.sv
rtl/polygon_plane_clip_top.sv
rtl/pcl_checker.sv
tb/clip_checker.sv
tb/tb_top.sv
